### sv/telemetry_packet_framer_core_defines.svh
// Assertion macros shared by the telemetry packet framer checker.
// Depends on nothing; included by the checker file.
`ifndef TELEMETRY_PACKET_FRAMER_CORE_DEFINES_SVH
`define TELEMETRY_PACKET_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("telemetry framer check failed");

// Next-cycle implication, disabled while reset is held.
`define TPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("telemetry framer check failed");

`endif

### sv/tpf_pkg.sv
// Shared types and constants of the telemetry packet framer.
// Depends on nothing; used by every framer module but the checker.
package tpf_pkg;

    localparam int BURST_MAX = 8;
    localparam int IDX_W     = $clog2(BURST_MAX);

    localparam logic [7:0] SYNC_A = 8'hFA;
    localparam logic [7:0] SYNC_B = 8'hF3;
    localparam logic [7:0] SYNC_C = 8'h20;

    localparam logic [IDX_W-1:0] LAST_HDR    = IDX_W'(5);
    localparam logic [IDX_W-1:0] LAST_HDR_CK = IDX_W'(7);
    localparam logic [IDX_W-1:0] LAST_PAY    = IDX_W'(0);
    localparam logic [IDX_W-1:0] LAST_PAY_CK = IDX_W'(2);

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
        logic                      cksum;
    } t_burst;

endpackage

### sv/tpf_frame_calc.sv
// Input register, packet state and per-word byte burst calculation.
// Depends on tpf_pkg.
module tpf_frame_calc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_cmd,
    input  logic [7:0]      i_packet_type,
    input  logic [15:0]     i_payload_length,
    input  logic [7:0]      i_data_byte,
    output logic            o_burst_valid,
    output tpf_pkg::t_burst o_burst,
    input  logic            i_burst_ready
);
    import tpf_pkg::*;

    logic        r_in_valid;
    logic        r_cmd;
    logic [7:0]  r_type;
    logic [15:0] r_len;
    logic [7:0]  r_data;
    logic        r_in_packet;
    logic [15:0] r_remaining;
    logic [15:0] r_sum;

    logic        n_in_packet;
    logic [15:0] n_remaining;
    logic [15:0] n_sum;

    logic        has_results;
    logic        done;
    logic        process;
    logic        accept;
    logic [15:0] sum_hdr;
    logic [15:0] sum_pay;
    logic [15:0] rem_dec;
    t_burst      burst;

    always_comb begin
        sum_hdr = {8'h00, SYNC_A} + {8'h00, SYNC_B} + {8'h00, SYNC_C} + {8'h00, r_type}
                + {8'h00, r_len[15:8]} + {8'h00, r_len[7:0]};
        sum_pay = r_sum + {8'h00, r_data};
        rem_dec = r_remaining - 16'd1;
        done = (rem_dec == 16'd0);

        burst       = '0;
        has_results = 1'b0;
        n_in_packet = r_in_packet;
        n_remaining = r_remaining;
        n_sum       = r_sum;

        if (r_cmd == CMD_START) begin
            has_results    = 1'b1;
            burst.bytes[0] = SYNC_A;
            burst.bytes[1] = SYNC_B;
            burst.bytes[2] = SYNC_C;
            burst.bytes[3] = r_type;
            burst.bytes[4] = r_len[15:8];
            burst.bytes[5] = r_len[7:0];
            burst.bytes[6] = sum_hdr[15:8];
            burst.bytes[7] = sum_hdr[7:0];
            burst.cksum    = (r_len == 16'd0);
            burst.last_idx = (r_len == 16'd0) ? LAST_HDR_CK : LAST_HDR;
            n_sum          = sum_hdr;
            n_remaining    = r_len;
            n_in_packet    = (r_len != 16'd0);
        end else if (r_in_packet) begin
            has_results    = 1'b1;
            burst.bytes[0] = r_data;
            burst.bytes[1] = sum_pay[15:8];
            burst.bytes[2] = sum_pay[7:0];
            burst.cksum    = done;
            burst.last_idx = done ? LAST_PAY_CK : LAST_PAY;
            n_sum          = sum_pay;
            n_remaining    = rem_dec;
            n_in_packet    = !done;
        end
    end

    assign process       = r_in_valid && (!has_results || i_burst_ready);
    assign o_stall       = r_in_valid && !process;
    assign accept        = i_valid && !o_stall;
    assign o_burst_valid = r_in_valid && has_results;
    assign o_burst       = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_packet <= 1'b0;
            r_remaining <= 16'd0;
            r_sum       <= 16'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_in_packet <= n_in_packet;
                r_remaining <= n_remaining;
                r_sum       <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_type <= i_packet_type;
            r_len  <= i_payload_length;
            r_data <= i_data_byte;
        end
    end

endmodule

### sv/tpf_burst_out.sv
// Result register that holds one word's byte burst and hands it out a byte at a time.
// Depends on tpf_pkg.
module tpf_burst_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load_valid,
    input  tpf_pkg::t_burst i_burst,
    output logic            o_load_ready,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_frame_byte,
    output logic            o_run_last,
    output logic            o_packet_end
);
    import tpf_pkg::*;

    logic             r_valid;
    t_burst           r_burst;
    logic [IDX_W-1:0] r_idx;

    logic take;
    logic is_last;
    logic free;

    assign take         = r_valid && !i_stall;
    assign is_last      = (r_idx == r_burst.last_idx);
    assign free         = !r_valid || (take && is_last);
    assign o_load_ready = free;

    assign o_valid      = r_valid;
    assign o_frame_byte = r_burst.bytes[r_idx];
    assign o_run_last   = is_last;
    assign o_packet_end = is_last && r_burst.cksum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (free) begin
            r_valid <= i_load_valid;
            r_idx   <= '0;
        end else if (take) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (free && i_load_valid) begin
            r_burst <= i_burst;
        end
    end

endmodule

### sv/telemetry_packet_framer_core.sv
// The first byte of a word's result shows on the output once the word has passed the input
// register and been loaded into the result register. Throughput: one word per cycle for payload
// words while the output does not stall; a closing payload word gives three bytes, a start word
// six, or eight with a zero length, handed out by the result register one byte per cycle while i_stall is low.
// Reset is synchronous and active low; it clears all valid flags and the packet state.
// Depends on tpf_pkg, tpf_frame_calc and tpf_burst_out.
module telemetry_packet_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_packet_type,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_run_last,
    output logic        o_packet_end
);
    import tpf_pkg::*;

    logic   burst_valid;
    logic   burst_ready;
    t_burst burst;

    tpf_frame_calc u_calc (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_packet_type    (i_packet_type),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .o_burst_valid    (burst_valid),
        .o_burst          (burst),
        .i_burst_ready    (burst_ready)
    );

    tpf_burst_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (burst_valid),
        .i_burst      (burst),
        .o_load_ready (burst_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_run_last   (o_run_last),
        .o_packet_end (o_packet_end)
    );

endmodule

### sv/tpf_checker.sv
// Port-level checks of the telemetry packet framer, bound to the top level.
// Depends on telemetry_packet_framer_core_defines.svh.
`include "telemetry_packet_framer_core_defines.svh"

module tpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_cmd,
    input logic [7:0]  i_packet_type,
    input logic [15:0] i_payload_length,
    input logic [7:0]  i_data_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_frame_byte,
    input logic        o_run_last,
    input logic        o_packet_end
);

    `TPF_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, o_valid && o_packet_end, o_run_last)
    `TPF_ASSERT_NEXT(a_burst_no_gap, i_clk, i_rst_n, o_valid && !i_stall && !o_run_last, o_valid)
    `TPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_frame_byte) && $stable(o_run_last) && $stable(o_packet_end))

endmodule

bind telemetry_packet_framer_core tpf_checker u_tpf_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for telemetry_packet_framer_core: directed and random command words, with a
// scoreboard class that predicts the framed byte stream and checks every output byte.
// Depends on tpf_pkg and the framer RTL.
module tb;
    import tpf_pkg::*;

    localparam logic [7:0] SYNC0        = 8'hFA;
    localparam logic [7:0] SYNC1        = 8'hF3;
    localparam logic [7:0] SYNC2        = 8'h20;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         RANDOM_WORDS = 100;
    localparam int         TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       packet_end;
    } t_frame_rec;

    class t_scoreboard;
        t_frame_rec  frame_q[$];
        bit          pkt_open;
        logic [15:0] bytes_left;
        logic [15:0] cksum;
        int          byte_no;

        function new();
            pkt_open   = 1'b0;
            bytes_left = 16'h0000;
            cksum      = 16'h0000;
            byte_no    = 0;
        endfunction

        function void push_frame_byte(logic [7:0] b, bit summed, bit closes);
            t_frame_rec rec;
            if (summed) begin
                cksum = cksum + {8'h00, b};
            end
            rec.frame_byte = b;
            rec.run_last   = 1'b0;
            rec.packet_end = closes;
            frame_q.push_back(rec);
        endfunction

        function void close_packet();
            push_frame_byte(cksum[15:8], 1'b0, 1'b0);
            push_frame_byte(cksum[7:0], 1'b0, 1'b1);
            pkt_open = 1'b0;
        endfunction

        function int note_word(t_cmd cmd, logic [7:0] ptype, logic [15:0] plen,
                               logic [7:0] dbyte);
            int         n_prev;
            t_frame_rec rec;
            n_prev = frame_q.size();
            if (cmd == CMD_START) begin
                cksum = 16'h0000;
                push_frame_byte(SYNC0, 1'b1, 1'b0);
                push_frame_byte(SYNC1, 1'b1, 1'b0);
                push_frame_byte(SYNC2, 1'b1, 1'b0);
                push_frame_byte(ptype, 1'b1, 1'b0);
                push_frame_byte(plen[15:8], 1'b1, 1'b0);
                push_frame_byte(plen[7:0], 1'b1, 1'b0);
                bytes_left = plen;
                pkt_open   = 1'b1;
                if (bytes_left == 16'h0000) begin
                    close_packet();
                end
            end else if (pkt_open) begin
                push_frame_byte(dbyte, 1'b1, 1'b0);
                bytes_left = bytes_left - 16'h0001;
                if (bytes_left == 16'h0000) begin
                    close_packet();
                end
            end
            if (frame_q.size() > n_prev) begin
                rec = frame_q.pop_back();
                rec.run_last = 1'b1;
                frame_q.push_back(rec);
            end
            return frame_q.size() - n_prev;
        endfunction

        function string check_byte(logic [7:0] fb, logic rl, logic pe);
            t_frame_rec want;
            string      msg;
            byte_no++;
            if (frame_q.size() == 0) begin
                return $sformatf("output byte %0d unexpected: %02h run_last %0d packet_end %0d",
                                 byte_no, fb, rl, pe);
            end
            want = frame_q.pop_front();
            msg  = "";
            if (fb !== want.frame_byte) begin
                msg = {msg, $sformatf(" frame_byte %02h/%02h", fb, want.frame_byte)};
            end
            if (rl !== want.run_last) begin
                msg = {msg, $sformatf(" run_last %0d/%0d", rl, want.run_last)};
            end
            if (pe !== want.packet_end) begin
                msg = {msg, $sformatf(" packet_end %0d/%0d", pe, want.packet_end)};
            end
            if (msg != "") begin
                msg = {$sformatf("output byte %0d (got/want):", byte_no), msg};
            end
            return msg;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_cmd;
    logic [7:0]  i_packet_type;
    logic [15:0] i_payload_length;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_frame_byte;
    logic        o_run_last;
    logic        o_packet_end;

    t_scoreboard sb;
    int          errors = 0;
    int          counted = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    telemetry_packet_framer_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_packet_type    (i_packet_type),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_byte     (o_frame_byte),
        .o_run_last       (o_run_last),
        .o_packet_end     (o_packet_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task automatic send_word(t_cmd cmd, logic [7:0] ptype, logic [15:0] plen,
                             logic [7:0] dbyte);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid          = 1'b1;
        i_cmd            = cmd;
        i_packet_type    = ptype;
        i_payload_length = plen;
        i_data_byte      = dbyte;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (sb.note_word(cmd, ptype, plen, dbyte) > 0) begin
            counted++;
        end
    endtask

    task automatic start_pkt(logic [7:0] ptype, logic [15:0] plen);
        send_word(CMD_START, ptype, plen, 8'($urandom()));
    endtask

    task automatic pay(logic [7:0] dbyte);
        send_word(CMD_PAYLOAD, 8'($urandom()), 16'($urandom()), dbyte);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.frame_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin : sink
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                hold    = 0;
                i_stall = 1'b0;
            end else if (hold > 0) begin
                hold--;
                i_stall = 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                hold    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(8, 40);
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            msg = sb.check_byte(o_frame_byte, o_run_last, o_packet_end);
            if (msg != "") begin
                report(msg);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int          sel;
        int          npay;
        logic [7:0]  ptype;
        logic [15:0] plen;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_cmd            = CMD_START;
        i_packet_type    = 8'h00;
        i_payload_length = 16'h0000;
        i_data_byte      = 8'h00;
        i_stall          = 1'b0;
        sb               = new();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        start_pkt(8'h00, 16'h0000);
        pay(8'h5A);
        start_pkt(8'hFF, 16'hFFFF);
        pay(8'hFF);
        pay(8'h00);
        start_pkt(8'hA5, 16'h0001);
        pay(8'hFF);
        pay(8'h00);
        start_pkt(8'h3C, 16'h0003);
        pay(8'h00);
        pay(8'hAA);
        pay(8'h55);
        start_pkt(8'h81, 16'h8000);
        pay(8'h7F);
        start_pkt(8'h18, 16'h0002);
        pay(8'hFF);
        pay(8'hFF);
        start_pkt(8'h00, 16'h0000);
        drain();

        counted = 0;
        while (counted < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 15) begin
                calm = !calm;
            end
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                pay(8'($urandom()));
            end else begin
                ptype = 8'($urandom());
                if (sel < 18) begin
                    plen = 16'($urandom());
                    npay = $urandom_range(0, 3);
                    if (npay > plen) begin
                        npay = plen;
                    end
                end else if (sel < 70) begin
                    plen = 16'($urandom_range(0, 4));
                    npay = plen;
                end else begin
                    plen = 16'($urandom_range(5, 12));
                    npay = plen;
                end
                start_pkt(ptype, plen);
                repeat (npay) pay(8'($urandom()));
            end
            if ($urandom_range(0, 99) < 8) begin
                drain();
            end
        end

        drain();
        calm = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && sb.frame_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
